[rtl/voxel_column_surface_heightmap_macros.svh]
// Assertion helpers, sampled on clk, inactive while arst_n is low.
`ifndef VOXEL_COLUMN_SURFACE_HEIGHTMAP_MACROS_SVH
`define VOXEL_COLUMN_SURFACE_HEIGHTMAP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VCSH_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define VCSH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/vcsh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vcsh_pkg;

	localparam int CHUNK_SIZE    = 32;
	localparam int COLUMN_HEIGHT = 64;
	localparam int OCC_W         = 64;
	localparam int HGT_W         = 6;
	localparam int CMP_W         = HGT_W + 1;
	localparam int IDX_W         = $clog2(CHUNK_SIZE);
	localparam int REM_W         = $clog2(CHUNK_SIZE + 4);
	localparam int OUT_TDATA_W   = 8;

	typedef struct packed {
		logic cap;
		logic up_en;
		logic down_en;
		logic load_out;
		logic last;
	} vcsh_cmd_t;

	typedef struct packed {
		logic row_end;
		logic chunk_end;
	} vcsh_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UP   = 4'b0010,
		ST_DOWN = 4'b0100,
		ST_EMIT = 4'b1000
	} vcsh_state_t;

	// index of the lowest set bit, zero when none
	function automatic logic [HGT_W-1:0] lsb_idx(input logic [OCC_W-1:0] v);
		logic [HGT_W-1:0] r;
		r = '0;
		for (int i = OCC_W - 1; i >= 0; i--) begin
			if (v[i])
				r = HGT_W'(i);
		end
		return r;
	endfunction

	// index of the highest set bit, zero when none
	function automatic logic [HGT_W-1:0] msb_idx(input logic [OCC_W-1:0] v);
		logic [HGT_W-1:0] r;
		r = '0;
		for (int i = 0; i < OCC_W; i++) begin
			if (v[i])
				r = HGT_W'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/vcsh_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_column_surface_heightmap_macros.svh"
module vcsh_dp
	import vcsh_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire vcsh_cmd_t              cmd,
	input  wire logic [OCC_W-1:0]       occ_in,
	output      vcsh_stat_t             stat,
	output      logic [OUT_TDATA_W-1:0] out_data,
	output      logic                   out_last
);

	logic [OCC_W-1:0] occ_q;
	logic [HGT_W-1:0] up_q;
	logic [HGT_W-1:0] cur_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic [HGT_W-1:0] oh_q;
	logic             olast_q;

	logic [HGT_W-1:0] start;
	logic [OCC_W-1:0] up_cand;
	logic [OCC_W-1:0] dn_cand;
	logic [HGT_W-1:0] up_next;
	logic [HGT_W-1:0] dn_next;

	// cursor restarts at zero on the first column of a row
	assign start = (col_q == '0) ? '0 : cur_q;

	// up scan: first empty cell at or above the cursor, below the top cell, else the top cell
	always_comb begin
		for (int k = 0; k < OCC_W; k++) begin
			up_cand[k] = !occ_q[k] && (CMP_W'(k) >= {1'b0, start})
				&& (k < COLUMN_HEIGHT - 1);
		end
	end
	assign up_next = (|up_cand) ? lsb_idx(up_cand) : HGT_W'(COLUMN_HEIGHT - 1);

	// down scan: one above the highest solid cell below the up position, floor 1, zero when up is zero
	always_comb begin
		for (int k = 0; k < OCC_W; k++) begin
			dn_cand[k] = occ_q[k] && (CMP_W'(k) < {1'b0, up_q});
		end
	end

	always_comb begin
		priority if (up_q == '0)
			dn_next = '0;
		else if (|dn_cand)
			dn_next = msb_idx(dn_cand) + HGT_W'(1);
		else
			dn_next = HGT_W'(1);
	end

	always_comb begin
		stat.row_end   = (col_q == IDX_W'(CHUNK_SIZE - 1));
		stat.chunk_end = stat.row_end && (row_q == IDX_W'(CHUNK_SIZE - 1));
	end

	always_ff @(posedge clk) begin
		if (cmd.cap)
			occ_q <= occ_in;
		if (cmd.up_en)
			up_q <= up_next;
		if (cmd.load_out) begin
			oh_q    <= cur_q;
			olast_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.down_en) begin
			cur_q <= dn_next;
			if (stat.row_end) begin
				col_q <= '0;
				row_q <= stat.chunk_end ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	assign out_data = {(OUT_TDATA_W - HGT_W)'(0), oh_q};
	assign out_last = olast_q;

	`VCSH_ASSERT_NEXT(a_dn_floor, cmd.down_en && (up_q != '0), cur_q != '0)
	`VCSH_ASSERT_NEXT(a_dn_not_above, cmd.down_en, cur_q <= $past(up_q))

endmodule
`default_nettype wire

[rtl/vcsh_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "voxel_column_surface_heightmap_macros.svh"
module vcsh_ctrl
	import vcsh_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	output      logic       out_valid,
	input  wire logic       out_ready,
	input  wire vcsh_stat_t stat,
	output      vcsh_cmd_t  cmd
);

	vcsh_state_t      state_q;
	logic [REM_W-1:0] rem_q;
	logic             chunk_q;
	logic             ovalid_q;
	logic             slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !ovalid_q || out_ready;

	always_comb begin
		cmd.cap      = in_valid && in_ready;
		cmd.up_en    = (state_q == ST_UP);
		cmd.down_en  = (state_q == ST_DOWN);
		cmd.load_out = (state_q == ST_EMIT) && slot_free;
		cmd.last     = chunk_q && (rem_q == REM_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rem_q    <= '0;
			chunk_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.load_out)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.cap)
						state_q <= ST_UP;
				end
				ST_UP: begin
					state_q <= ST_DOWN;
				end
				ST_DOWN: begin
					// one entry, one more at row end, size+1 padding at chunk end
					rem_q <= REM_W'(1) + REM_W'(stat.row_end)
						+ (stat.chunk_end ? REM_W'(CHUNK_SIZE + 1) : '0);
					chunk_q <= stat.chunk_end;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						rem_q <= rem_q - REM_W'(1);
						if (rem_q == REM_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;

	`VCSH_ASSERT_SAME(a_emit_count, state_q == ST_EMIT, rem_q != '0)
	`VCSH_ASSERT_SAME(a_no_overwrite, cmd.load_out, !ovalid_q || out_ready)
	`VCSH_ASSERT_NEXT(a_cap_starts_scan, cmd.cap, state_q == ST_UP)

endmodule
`default_nettype wire

[rtl/voxel_column_surface_heightmap.sv]
// A column is accepted only while idle; no new column is taken until all its entries are out.
// Each column emits one entry, one more at a row end and CHUNK_SIZE + 1 more at chunk end;
// it passes the up and down bit scans, then the single output register, which emits one
// entry per cycle while the output is not stalled.
// Reset: arst_n clears the controller, the output valid, the cursor and both indices.
`timescale 1ns / 1ps
`default_nettype none
module voxel_column_surface_heightmap
	import vcsh_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	input  wire logic [OCC_W-1:0]       s_tdata,  // [63:0] column_occupancy
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [OUT_TDATA_W-1:0] m_tdata,  // [5:0] surface_height, [7:6] zero
	output      logic                   m_tlast   // last_of_chunk
);

	vcsh_cmd_t  cmd;
	vcsh_stat_t stat;

	vcsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vcsh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.occ_in   (s_tdata),
		.stat     (stat),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);

endmodule
`default_nettype wire
